>>> hdl/waypoint_follower_2d_defines.svh
// Assertion macros used by the waypoint follower controller.
`ifndef WAYPOINT_FOLLOWER_2D_DEFINES_SVH
`define WAYPOINT_FOLLOWER_2D_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WF2D_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WF2D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/wf2d_pkg.sv
`timescale 1ns / 1ps
package wf2d_pkg;

   // Request codes.
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;
   localparam logic [1:0] REQ_PLACE = 2'd3;

   // Register indexes.
   localparam logic CSR_SPEED = 1'b0;
   localparam logic CSR_MODE  = 1'b1;

   // Final iteration counter values of the square root and divider units.
   localparam logic [5:0] SQRT_LAST = 6'd32;
   localparam logic [5:0] DIV_LAST  = 6'd16;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [5:0]         wp_index;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic [6:0]         path_length;
      logic [15:0]        tick_time;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic               moving;
      logic [5:0]         waypoint_index;
      logic               arrived;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_TGT,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQRT,
      ST_CMP,
      ST_DIV,
      ST_MUL,
      ST_MOVE,
      ST_ADV_RD,
      ST_ADV_WR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic accept;
      logic clr_follow;
      logic load_tgt;
      logic sq_x;
      logic sq_y;
      logic sqrt_step;
      logic div_init;
      logic div_step;
      logic mul;
      logic move;
      logic inc_index;
      logic finish;
      logic load_target;
   } cmd_type;

   typedef struct packed {
      logic following;
      logic tick_stop;
      logic smooth;
      logic dist_le_step;
      logic at_end;
   } status_type;

endpackage

>>> hdl/wf2d_ram.sv
`timescale 1ns / 1ps
module wf2d_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> hdl/wf2d_ctrl.sv
`timescale 1ns / 1ps
`include "waypoint_follower_2d_defines.svh"
module wf2d_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_type,
   input  wf2d_pkg::status_type status,
   output wf2d_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);

   wf2d_pkg::state_type state_ff, state_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic                is_tick;

   assign is_tick = (req_type == wf2d_pkg::REQ_TICK);

   // State and iteration counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wf2d_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // The counter restarts on every change of state.
   assign cnt_in = (state_in != state_ff) ? 6'd0 : cnt_ff + 6'd1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wf2d_pkg::ST_IDLE: begin
            if (start) begin
               if (is_tick && status.following && !status.tick_stop) begin
                  state_in = wf2d_pkg::ST_LOAD_TGT;
               end else begin
                  state_in = wf2d_pkg::ST_RESP;
               end
            end
         end
         wf2d_pkg::ST_LOAD_TGT: state_in = wf2d_pkg::ST_SQ_X;
         wf2d_pkg::ST_SQ_X:     state_in = wf2d_pkg::ST_SQ_Y;
         wf2d_pkg::ST_SQ_Y:     state_in = wf2d_pkg::ST_SQRT;
         wf2d_pkg::ST_SQRT: begin
            if (cnt_ff == wf2d_pkg::SQRT_LAST) begin
               state_in = wf2d_pkg::ST_CMP;
            end
         end
         wf2d_pkg::ST_CMP: begin
            if (!status.dist_le_step) begin
               state_in = wf2d_pkg::ST_DIV;
            end else if (!status.at_end && status.smooth) begin
               state_in = wf2d_pkg::ST_ADV_RD;
            end else begin
               state_in = wf2d_pkg::ST_RESP;
            end
         end
         wf2d_pkg::ST_DIV: begin
            if (cnt_ff == wf2d_pkg::DIV_LAST) begin
               state_in = wf2d_pkg::ST_MUL;
            end
         end
         wf2d_pkg::ST_MUL:    state_in = wf2d_pkg::ST_MOVE;
         wf2d_pkg::ST_MOVE:   state_in = wf2d_pkg::ST_RESP;
         wf2d_pkg::ST_ADV_RD: state_in = wf2d_pkg::ST_ADV_WR;
         wf2d_pkg::ST_ADV_WR: state_in = wf2d_pkg::ST_RESP;
         wf2d_pkg::ST_RESP:   state_in = wf2d_pkg::ST_IDLE;
         default:             state_in = wf2d_pkg::ST_IDLE;
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         wf2d_pkg::ST_IDLE: begin
            cmd.accept     = start;
            cmd.clr_follow = start && is_tick && status.following && status.tick_stop;
         end
         wf2d_pkg::ST_LOAD_TGT: cmd.load_tgt  = 1'b1;
         wf2d_pkg::ST_SQ_X:     cmd.sq_x      = 1'b1;
         wf2d_pkg::ST_SQ_Y:     cmd.sq_y      = 1'b1;
         wf2d_pkg::ST_SQRT:     cmd.sqrt_step = 1'b1;
         wf2d_pkg::ST_CMP: begin
            cmd.div_init  = !status.dist_le_step;
            cmd.finish    = status.dist_le_step && status.at_end;
            cmd.inc_index = status.dist_le_step && !status.at_end;
         end
         wf2d_pkg::ST_DIV:    cmd.div_step    = 1'b1;
         wf2d_pkg::ST_MUL:    cmd.mul         = 1'b1;
         wf2d_pkg::ST_MOVE:   cmd.move        = 1'b1;
         wf2d_pkg::ST_ADV_RD: cmd            = '0;
         wf2d_pkg::ST_ADV_WR: cmd.load_target = 1'b1;
         wf2d_pkg::ST_RESP:   cmd            = '0;
         default:             cmd            = '0;
      endcase
   end

   assign busy      = (state_ff != wf2d_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == wf2d_pkg::ST_RESP);

   // A request that needs no motion is answered in the following cycle.
   `WF2D_ASSERT_NEXT(a_short_resp, clock, reset, start && !busy && !is_tick, rsp_valid,
      "non-tick request not answered in the next cycle")
   // The result strobe lasts one cycle and returns to idle.
   `WF2D_ASSERT_NEXT(a_strobe_once, clock, reset, rsp_valid, !rsp_valid && !busy,
      "result strobe longer than one cycle")
   // The square root runs its full count before the compare.
   `WF2D_ASSERT_NOW(a_sqrt_count, clock, reset, state_ff == wf2d_pkg::ST_CMP,
      $past(cnt_ff) == wf2d_pkg::SQRT_LAST, "square root ended early")
   // Finishing and advancing never happen together.
   `WF2D_ASSERT_NOW(a_cmp_excl, clock, reset, cmd.finish, !cmd.inc_index && !cmd.div_init,
      "conflicting compare commands")

endmodule

>>> hdl/wf2d_datapath.sv
`timescale 1ns / 1ps
module wf2d_datapath #(
   parameter int MAX_WAYPOINTS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  wf2d_pkg::req_payload_type req_payload,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [31:0]              csr_wdata,
   input  wf2d_pkg::cmd_type         cmd,
   output wf2d_pkg::status_type      status,
   output wf2d_pkg::rsp_payload_type rsp_payload
);

   localparam int AW = $clog2(MAX_WAYPOINTS);

   // Configuration.
   logic [31:0] speed_ff;
   logic        mode_ff;

   // Architectural state.
   logic [31:0] pos_x_ff, pos_y_ff, tgt_x_ff, tgt_y_ff;
   logic [5:0]  index_ff;
   logic [6:0]  length_ff;
   logic        follow_ff, arrived_ff;

   // Working registers of one tick.
   logic [31:0] step_ff, aim_x_ff, aim_y_ff;
   logic [32:0] ax_ff, ay_ff;
   logic        neg_x_ff, neg_y_ff;
   logic [65:0] acc_ff;
   logic [34:0] rem_ff;
   logic [32:0] root_ff;
   logic [33:0] rx_ff, ry_ff;
   logic [16:0] qx_ff, qy_ff;
   logic [32:0] dlx_ff, dly_ff;

   logic [6:0]  len_sat, rd_idx;
   logic        wr_en;
   logic [63:0] rd_data;
   logic [31:0] sel_x, sel_y;
   logic signed [32:0] dx, dy;
   logic [32:0] sq_op;
   logic [65:0] sq_prod;
   logic [36:0] rem_tr, root_tr;
   logic [33:0] dist_ext;
   logic [7:0]  idx_ext;

   // Waypoint table: x in the upper half, y in the lower half.
   assign wr_en = cmd.accept && (req_payload.req_type == wf2d_pkg::REQ_LOAD)
                  && ({26'd0, req_payload.wp_index} < 32'(MAX_WAYPOINTS));
   assign rd_idx = mode_ff ? {1'b0, index_ff} : {1'b0, index_ff} + 7'd1;

   wf2d_ram #(.WIDTH(64), .DEPTH(MAX_WAYPOINTS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_payload.wp_index)),
      .wr_data ({req_payload.coord_x, req_payload.coord_y}),
      .rd_addr (AW'(rd_idx)),
      .rd_data (rd_data)
   );

   assign len_sat = ({25'd0, req_payload.path_length} > 32'(MAX_WAYPOINTS))
                    ? 7'(MAX_WAYPOINTS) : req_payload.path_length;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= '0;
         mode_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            wf2d_pkg::CSR_SPEED: speed_ff <= csr_wdata;
            wf2d_pkg::CSR_MODE:  mode_ff  <= csr_wdata[0];
            default:             mode_ff  <= mode_ff;
         endcase
      end
   end

   // Target of this tick and its offset from the agent.
   assign sel_x = mode_ff ? tgt_x_ff : rd_data[63:32];
   assign sel_y = mode_ff ? tgt_y_ff : rd_data[31:0];
   assign dx = $signed({sel_x[31], sel_x}) - $signed({pos_x_ff[31], pos_x_ff});
   assign dy = $signed({sel_y[31], sel_y}) - $signed({pos_y_ff[31], pos_y_ff});

   // One squaring multiplier shared by both axes.
   assign sq_op   = cmd.sq_y ? ay_ff : ax_ff;
   assign sq_prod = sq_op * sq_op;

   // Square root step: two radicand bits per cycle.
   assign rem_tr  = {rem_ff, acc_ff[65:64]};
   assign root_tr = {2'b00, root_ff[32:0], 2'b01};

   assign dist_ext = {1'b0, root_ff};
   assign idx_ext  = {2'b00, index_ff};

   // Architectural state updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         tgt_x_ff   <= '0;
         tgt_y_ff   <= '0;
         index_ff   <= '0;
         length_ff  <= '0;
         follow_ff  <= 1'b0;
         arrived_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            arrived_ff <= 1'b0;
            case (req_payload.req_type)
               wf2d_pkg::REQ_START: begin
                  length_ff <= len_sat;
                  index_ff  <= '0;
                  follow_ff <= (len_sat >= (mode_ff ? 7'd1 : 7'd2));
               end
               wf2d_pkg::REQ_PLACE: begin
                  pos_x_ff <= req_payload.coord_x;
                  pos_y_ff <= req_payload.coord_y;
                  tgt_x_ff <= req_payload.coord_x;
                  tgt_y_ff <= req_payload.coord_y;
               end
               default: ;
            endcase
         end
         if (cmd.clr_follow) begin
            follow_ff <= 1'b0;
         end
         if (cmd.inc_index) begin
            index_ff <= index_ff + 6'd1;
         end
         if (cmd.finish) begin
            pos_x_ff   <= aim_x_ff;
            pos_y_ff   <= aim_y_ff;
            follow_ff  <= 1'b0;
            arrived_ff <= 1'b1;
            if (mode_ff) begin
               index_ff <= 6'(length_ff - 7'd1);
            end
         end
         if (cmd.load_target) begin
            tgt_x_ff <= rd_data[63:32];
            tgt_y_ff <= rd_data[31:0];
         end
         if (cmd.move) begin
            pos_x_ff <= neg_x_ff ? pos_x_ff - dlx_ff[31:0] : pos_x_ff + dlx_ff[31:0];
            pos_y_ff <= neg_y_ff ? pos_y_ff - dly_ff[31:0] : pos_y_ff + dly_ff[31:0];
         end
      end
   end

   // Arithmetic working registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         step_ff <= 32'((48'(speed_ff) * 48'(req_payload.tick_time)) >> 16);
      end
      if (cmd.load_tgt) begin
         aim_x_ff <= sel_x;
         aim_y_ff <= sel_y;
         neg_x_ff <= dx[32];
         neg_y_ff <= dy[32];
         ax_ff    <= dx[32] ? 33'(-dx) : 33'(dx);
         ay_ff    <= dy[32] ? 33'(-dy) : 33'(dy);
      end
      if (cmd.sq_x) begin
         acc_ff <= sq_prod;
      end
      if (cmd.sq_y) begin
         acc_ff  <= acc_ff + sq_prod;
         rem_ff  <= '0;
         root_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         acc_ff <= {acc_ff[63:0], 2'b00};
         if (rem_tr >= root_tr) begin
            rem_ff  <= 35'(rem_tr - root_tr);
            root_ff <= {root_ff[31:0], 1'b1};
         end else begin
            rem_ff  <= rem_tr[34:0];
            root_ff <= {root_ff[31:0], 1'b0};
         end
      end
      // Unit vector components by restoring division, one bit per cycle.
      if (cmd.div_init) begin
         rx_ff <= {1'b0, ax_ff};
         ry_ff <= {1'b0, ay_ff};
         qx_ff <= '0;
         qy_ff <= '0;
      end
      if (cmd.div_step) begin
         if (rx_ff >= dist_ext) begin
            rx_ff <= 34'({rx_ff - dist_ext, 1'b0});
            qx_ff <= {qx_ff[15:0], 1'b1};
         end else begin
            rx_ff <= {rx_ff[32:0], 1'b0};
            qx_ff <= {qx_ff[15:0], 1'b0};
         end
         if (ry_ff >= dist_ext) begin
            ry_ff <= 34'({ry_ff - dist_ext, 1'b0});
            qy_ff <= {qy_ff[15:0], 1'b1};
         end else begin
            ry_ff <= {ry_ff[32:0], 1'b0};
            qy_ff <= {qy_ff[15:0], 1'b0};
         end
      end
      if (cmd.mul) begin
         dlx_ff <= 33'((49'(step_ff) * 49'(qx_ff)) >> 16);
         dly_ff <= 33'((49'(step_ff) * 49'(qy_ff)) >> 16);
      end
   end

   // Status for the controller.
   assign status.following    = follow_ff;
   assign status.smooth       = mode_ff;
   assign status.tick_stop    = mode_ff ? (length_ff == 7'd0)
                                        : ({1'b0, index_ff} + 7'd1 >= length_ff);
   assign status.dist_le_step = (root_ff <= {1'b0, step_ff});
   assign status.at_end       = mode_ff ? (idx_ext + 8'd1 >= {1'b0, length_ff})
                                        : (idx_ext + 8'd2 >= {1'b0, length_ff});

   assign rsp_payload.pos_x          = pos_x_ff;
   assign rsp_payload.pos_y          = pos_y_ff;
   assign rsp_payload.moving         = follow_ff;
   assign rsp_payload.waypoint_index = index_ff;
   assign rsp_payload.arrived        = arrived_ff;

endmodule

>>> hdl/waypoint_follower_2d.sv
`timescale 1ns / 1ps
// Waypoint follower for a 2D agent in Q16.16 fixed point.
// Requests enter on req_payload and are accepted at a clock edge where start is
// high and busy is low; busy stays high until the transaction is answered.
// Request kinds: load a waypoint slot, start a path, place the agent, or tick.
// Every request gives exactly one result on rsp_payload, marked by rsp_valid
// for a single cycle; the receiver has no way to stall it.
// Load, start, place and an idle tick answer in the cycle after acceptance.
// A moving tick runs the target fetch, the squaring of x and of y, a bit-pair
// square root, the compare, a one-bit restoring divider for both axes, the
// step multiply and the position update.
// A tick that reaches a waypoint skips the divide and the move; in smooth
// mode, when the path goes on, the next target is read from the table first.
// The next request may be accepted in the cycle after the result strobe.
// csr_we writes speed (index 0) or follow mode (index 1); write
// them only while the block is idle.
// Reset clears position, target, path state and configuration registers; the
// waypoint table holds no defined values until loaded.
module waypoint_follower_2d #(
   parameter int MAX_WAYPOINTS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  wf2d_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   output wf2d_pkg::rsp_payload_type  rsp_payload,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [31:0]               csr_wdata
);

   wf2d_pkg::cmd_type    cmd;
   wf2d_pkg::status_type status;

   // Sequencer for one transaction.
   wf2d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_payload.req_type),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // State, waypoint table and arithmetic units.
   wf2d_datapath #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule
